>>> rtl/core/irs_pkg.sv
package irs_pkg;

  localparam int IDX_W     = 10;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 20;
  localparam int CFG_W     = 11;
  localparam int STATUS_W  = 2;
  localparam int LANE_W    = 2;
  localparam int LANES     = 1 << LANE_W;
  localparam int ROW_W     = IDX_W - LANE_W;
  localparam int SLOT_SPACE = 1 << IDX_W;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 11'd1024;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BOOK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ADMITTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REFUSED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

  typedef struct packed {
    logic             operation;
    logic [IDX_W-1:0] slot_index;
    logic [VAL_W-1:0] capacity_value;
    logic [VAL_W-1:0] amount;
    logic [IDX_W-1:0] first_slot;
    logic [IDX_W-1:0] last_slot;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] booking_number;
    logic [CNT_OUT_W-1:0] first_refused;
  } out_item_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             upd_en;
    logic [ROW_W-1:0] pend_row;
    logic             load_en;
    logic [IDX_W-1:0] load_slot;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } cell_ctl_t;

endpackage

>>> rtl/core/irs_chan_if.sv
interface irs_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/irs_ram.sv
module irs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/core/irs_cell.sv
module irs_cell #(
  parameter int LANE        = 0,
  parameter int ROWS        = 256,
  parameter int AMOUNT_BITS = 32
) (
  input  logic                   clk,
  input  irs_pkg::cell_ctl_t     ctl,
  input  logic [AMOUNT_BITS-1:0] need,
  input  logic [AMOUNT_BITS-1:0] load_value,
  input  logic                   fit_in,
  output logic                   fit_out
);
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [AMOUNT_BITS-1:0]   rdata;
  logic [irs_pkg::IDX_W-1:0] slot;
  logic                     in_range;
  logic                     load_hit;
  logic                     we;
  logic [ROW_AW-1:0]        waddr;
  logic [AMOUNT_BITS-1:0]   wdata;

  // slot held by this lane in the row whose data is coming back
  assign slot     = {ctl.pend_row, irs_pkg::LANE_W'(LANE)};
  assign in_range = (slot >= ctl.lo) && (slot <= ctl.hi);
  assign fit_out  = fit_in & (!in_range || (rdata >= need));

  assign load_hit = ctl.load_en &&
                    (ctl.load_slot[irs_pkg::LANE_W-1:0] == irs_pkg::LANE_W'(LANE));
  assign we       = load_hit || (ctl.upd_en && in_range);

  always_comb begin
    if (ctl.load_en) begin
      waddr = ctl.load_slot[irs_pkg::LANE_W +: ROW_AW];
      wdata = load_value;
    end else begin
      waddr = ctl.pend_row[ROW_AW-1:0];
      wdata = rdata - need;
    end
  end

  irs_ram #(
    .WIDTH (AMOUNT_BITS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_row[ROW_AW-1:0]),
    .rdata (rdata)
  );
endmodule

>>> rtl/core/interval_reservation_admission.sv
// Interval capacity reservation with first-refusal tracking.
// in_ch carries one transaction per item: a load (operation 0) writes one slot
// capacity, a booking (operation 1) asks for amount over first_slot..last_slot.
// out_ch returns one transaction per booking (status, booking_number,
// first_refused); loads return nothing. cfg_we/cfg_wdata set slots_in_use.
// Slots are spread over four cells (slot mod 4), each with its own RAM; one
// row of four slots is visited per cycle and the fit flag ripples along cells.
// A load is written straight into its cell RAM. A booking that is ignored or
// has a bad range goes straight to the reply. A checked booking runs a check
// pass over its rows, then a write-back pass over them when it fits, then a
// reply. The single read port per cell RAM allows one row per cycle per pass.
// One item is worked on at a time; a new item is taken while the last result
// still sits in the output register. A reply waits while out_ch is stalled.
// Reset (synchronous, rst_n low) clears counters, the refusal flag and sets
// slots_in_use to 1024; capacity RAMs are not cleared and must be loaded.
module interval_reservation_admission #(
  parameter int SLOT_COUNT         = 1024,
  parameter int BOOKING_COUNT_BITS = 20,
  parameter int AMOUNT_BITS        = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  irs_chan_if.sink                  in_ch,
  irs_chan_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [irs_pkg::CFG_W-1:0] cfg_wdata
);
  localparam int USED   = (SLOT_COUNT < irs_pkg::SLOT_SPACE) ? SLOT_COUNT
                                                             : irs_pkg::SLOT_SPACE;
  localparam int ROWS   = (USED + irs_pkg::LANES - 1) / irs_pkg::LANES;
  localparam logic [31:0] SLOT_LIMIT = 32'(SLOT_COUNT);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_REPLY  = 2'd3;

  logic [1:0]                     state_r, state_nxt;
  logic [irs_pkg::CFG_W-1:0]      slots_in_use_r, slots_in_use_nxt;
  logic [BOOKING_COUNT_BITS-1:0]  counter_r, counter_nxt;
  logic                           refused_r, refused_nxt;
  logic [BOOKING_COUNT_BITS-1:0]  refused_num_r, refused_num_nxt;
  logic [AMOUNT_BITS-1:0]         need_r, need_nxt;
  logic [irs_pkg::IDX_W-1:0]      lo_r, lo_nxt;
  logic [irs_pkg::IDX_W-1:0]      hi_r, hi_nxt;
  logic [irs_pkg::ROW_W-1:0]      rd_row_r, rd_row_nxt;
  logic [irs_pkg::ROW_W-1:0]      end_row_r, end_row_nxt;
  logic                           issue_r, issue_nxt;
  logic                           pend_r, pend_nxt;
  logic [irs_pkg::ROW_W-1:0]      pend_row_r, pend_row_nxt;
  logic                           fit_r, fit_nxt;
  logic [irs_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  irs_pkg::out_item_t             out_data_r, out_data_nxt;

  irs_pkg::in_item_t              item;
  irs_pkg::cell_ctl_t             ctl;
  logic                           acc;
  logic                           bad_range;
  logic [irs_pkg::LANES:0]        fit_chain;

  assign item        = in_ch.data;
  assign in_ch.ready = (state_r == S_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign bad_range = (item.first_slot > item.last_slot) ||
                     ({1'b0, item.last_slot} >= slots_in_use_r) ||
                     (32'(item.last_slot) >= SLOT_LIMIT);

  always_comb begin
    ctl.rd_en     = issue_r;
    ctl.rd_row    = rd_row_r;
    ctl.upd_en    = (state_r == S_UPDATE) && pend_r;
    ctl.pend_row  = pend_row_r;
    ctl.load_en   = acc && (item.operation == irs_pkg::OP_LOAD) &&
                    (32'(item.slot_index) < SLOT_LIMIT);
    ctl.load_slot = item.slot_index;
    ctl.lo        = lo_r;
    ctl.hi        = hi_r;
  end

  assign fit_chain[0] = 1'b1;

  for (genvar g = 0; g < irs_pkg::LANES; g++) begin : g_cell
    irs_cell #(
      .LANE        (g),
      .ROWS        (ROWS),
      .AMOUNT_BITS (AMOUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .need       (need_r),
      .load_value (AMOUNT_BITS'(item.capacity_value)),
      .fit_in     (fit_chain[g]),
      .fit_out    (fit_chain[g+1])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    slots_in_use_nxt = slots_in_use_r;
    counter_nxt      = counter_r;
    refused_nxt      = refused_r;
    refused_num_nxt  = refused_num_r;
    need_nxt         = need_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    rd_row_nxt       = rd_row_r;
    end_row_nxt      = end_row_r;
    issue_nxt        = issue_r;
    pend_nxt         = 1'b0;
    pend_row_nxt     = rd_row_r;
    fit_nxt          = fit_r;
    status_nxt       = status_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;

    if (cfg_we) begin
      slots_in_use_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // row scan shared by the check and write-back passes
    if (issue_r) begin
      pend_nxt = 1'b1;
      if (rd_row_r == end_row_r) begin
        issue_nxt = 1'b0;
      end else begin
        rd_row_nxt = rd_row_r + 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (acc && (item.operation == irs_pkg::OP_BOOK)) begin
          if (counter_r != '1) begin
            counter_nxt = counter_r + 1'b1;
          end
          need_nxt    = AMOUNT_BITS'(item.amount);
          lo_nxt      = item.first_slot;
          hi_nxt      = item.last_slot;
          rd_row_nxt  = item.first_slot[irs_pkg::IDX_W-1:irs_pkg::LANE_W];
          end_row_nxt = item.last_slot[irs_pkg::IDX_W-1:irs_pkg::LANE_W];
          fit_nxt     = 1'b1;
          if (refused_r) begin
            status_nxt = irs_pkg::ST_IGNORED;
            state_nxt  = S_REPLY;
          end else if (bad_range) begin
            status_nxt = irs_pkg::ST_BAD_RANGE;
            state_nxt  = S_REPLY;
          end else begin
            issue_nxt = 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (pend_r) begin
          fit_nxt = fit_r & fit_chain[irs_pkg::LANES];
        end
        if (!issue_r && !pend_r) begin
          if (fit_r) begin
            issue_nxt  = 1'b1;
            rd_row_nxt = lo_r[irs_pkg::IDX_W-1:irs_pkg::LANE_W];
            state_nxt  = S_UPDATE;
          end else begin
            refused_nxt     = 1'b1;
            refused_num_nxt = counter_r;
            status_nxt      = irs_pkg::ST_REFUSED;
            state_nxt       = S_REPLY;
          end
        end
      end
      S_UPDATE: begin
        if (!issue_r && !pend_r) begin
          status_nxt = irs_pkg::ST_ADMITTED;
          state_nxt  = S_REPLY;
        end
      end
      S_REPLY: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.booking_number = irs_pkg::CNT_OUT_W'(counter_r);
          out_data_nxt.first_refused  = irs_pkg::CNT_OUT_W'(refused_num_nxt);
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      slots_in_use_r <= irs_pkg::SLOTS_RESET;
      counter_r      <= '0;
      refused_r      <= 1'b0;
      refused_num_r  <= '0;
      issue_r        <= 1'b0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      slots_in_use_r <= slots_in_use_nxt;
      counter_r      <= counter_nxt;
      refused_r      <= refused_nxt;
      refused_num_r  <= refused_num_nxt;
      issue_r        <= issue_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r     <= need_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    rd_row_r   <= rd_row_nxt;
    end_row_r  <= end_row_nxt;
    pend_row_r <= pend_row_nxt;
    fit_r      <= fit_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_refused_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    refused_r |=> refused_r)
    else $error("refusal flag cleared");

  a_update_after_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPDATE) |-> fit_r)
    else $error("write-back pass without a full fit");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r |-> (rd_row_r <= end_row_r))
    else $error("row scan ran past the last row");

  a_refused_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == irs_pkg::ST_REFUSED)) |->
      (out_data_r.first_refused == out_data_r.booking_number))
    else $error("refused reply carries a different first_refused");
`endif
endmodule

>>> sim/interval_reservation_admission_tb.sv
`timescale 1ns / 1ps

module interval_reservation_admission_tb;

  localparam int SLOTS = 1024;
  // checked bookings stay inside the low slots so few extra loads are needed
  localparam int WINDOW = 32;

  typedef struct {
    irs_pkg::in_item_t  item;
    bit                 has_reply;
    irs_pkg::out_item_t reply;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [irs_pkg::CFG_W-1:0] cfg_wdata = '0;

  irs_chan_if #(.data_t(irs_pkg::in_item_t)) in_ch ();
  irs_chan_if #(.data_t(irs_pkg::out_item_t)) out_ch ();

  interval_reservation_admission dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block
  logic [irs_pkg::VAL_W-1:0] cap_left [0:SLOTS-1];
  bit                        slot_loaded [0:SLOTS-1];
  bit [irs_pkg::CNT_OUT_W-1:0] bookings_seen;
  bit                          refusal_seen;
  bit [irs_pkg::CNT_OUT_W-1:0] refused_at;
  bit [irs_pkg::CFG_W-1:0]     slots_cfg;

  request_t           request_q[$];
  irs_pkg::out_item_t reply_q[$];
  request_t           staged;
  bit                 cur_has_reply;
  irs_pkg::out_item_t cur_reply;
  irs_pkg::out_item_t exp_reply;

  int idle_odds;
  int in_gap;
  int out_stall;
  int errors;
  int loads_done;
  int status_seen [0:3];
  int settings_cnt;

  function automatic int unsigned usable_slots();
    return (slots_cfg > SLOTS) ? SLOTS : 32'(slots_cfg);
  endfunction

  function automatic bit apply_request(input irs_pkg::in_item_t it,
                                       output irs_pkg::out_item_t res);
    int unsigned k;
    bit fits;
    res = '0;
    if (it.operation == irs_pkg::OP_LOAD) begin
      cap_left[it.slot_index] = it.capacity_value;
      slot_loaded[it.slot_index] = 1'b1;
      return 1'b0;
    end
    if (bookings_seen != '1) bookings_seen++;
    if (refusal_seen) begin
      res.status = irs_pkg::ST_IGNORED;
    end else if (it.first_slot > it.last_slot || it.last_slot >= usable_slots()) begin
      res.status = irs_pkg::ST_BAD_RANGE;
    end else begin
      fits = 1'b1;
      for (k = 32'(it.first_slot); k <= 32'(it.last_slot); k++)
        if (cap_left[k] < it.amount) fits = 1'b0;
      if (fits) begin
        for (k = 32'(it.first_slot); k <= 32'(it.last_slot); k++)
          cap_left[k] = cap_left[k] - it.amount;
        res.status = irs_pkg::ST_ADMITTED;
      end else begin
        refusal_seen = 1'b1;
        refused_at = bookings_seen;
        res.status = irs_pkg::ST_REFUSED;
      end
    end
    res.booking_number = bookings_seen;
    res.first_refused = refused_at;
    return 1'b1;
  endfunction

  task automatic push_request(input irs_pkg::in_item_t it);
    request_t req;
    req.item = it;
    req.has_reply = apply_request(it, req.reply);
    request_q.push_back(req);
  endtask

  task automatic queue_load(input int unsigned idx, input logic [irs_pkg::VAL_W-1:0] val);
    irs_pkg::in_item_t it;
    it.operation = irs_pkg::OP_LOAD;
    it.slot_index = irs_pkg::IDX_W'(idx);
    it.capacity_value = val;
    it.amount = $urandom;
    it.first_slot = irs_pkg::IDX_W'($urandom);
    it.last_slot = irs_pkg::IDX_W'($urandom);
    push_request(it);
  endtask

  task automatic queue_booking(input logic [irs_pkg::VAL_W-1:0] amt, input int unsigned lo,
                               input int unsigned hi);
    irs_pkg::in_item_t it;
    it.operation = irs_pkg::OP_BOOK;
    it.slot_index = irs_pkg::IDX_W'($urandom);
    it.capacity_value = $urandom;
    it.amount = amt;
    it.first_slot = irs_pkg::IDX_W'(lo);
    it.last_slot = irs_pkg::IDX_W'(hi);
    push_request(it);
  endtask

  function automatic logic [irs_pkg::VAL_W-1:0] rand_capacity();
    return ($urandom_range(0, 9) == 0) ? '1 : $urandom;
  endfunction

  // never let a checked booking read a slot that was not loaded
  task automatic cover_range(input int unsigned lo, input int unsigned hi);
    int unsigned k;
    for (k = lo; k <= hi; k++)
      if (!slot_loaded[k]) queue_load(k, rand_capacity());
  endtask

  function automatic logic [irs_pkg::VAL_W-1:0] min_left(input int unsigned lo,
                                                         input int unsigned hi);
    logic [irs_pkg::VAL_W-1:0] m;
    int unsigned k;
    m = '1;
    for (k = lo; k <= hi; k++)
      if (cap_left[k] < m) m = cap_left[k];
    return m;
  endfunction

  task automatic queue_bad_booking();
    int unsigned eff, lo, hi;
    eff = usable_slots();
    if (eff < SLOTS && $urandom_range(0, 1) == 0) begin
      hi = $urandom_range(eff, SLOTS - 1);
      lo = $urandom_range(0, hi);
    end else begin
      hi = $urandom_range(0, SLOTS - 2);
      lo = $urandom_range(hi + 1, SLOTS - 1);
    end
    queue_booking($urandom, lo, hi);
  endtask

  task automatic queue_random_step();
    int unsigned eff, win, lo, hi, len, r;
    logic [irs_pkg::VAL_W-1:0] m, amt;
    eff = usable_slots();
    win = (eff < WINDOW) ? eff : WINDOW;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if (win > 0 && $urandom_range(0, 1) == 0) queue_load($urandom_range(0, win - 1),
                                                          rand_capacity());
      else queue_load($urandom_range(0, SLOTS - 1), rand_capacity());
    end else if (eff == 0 || r < 45) begin
      queue_bad_booking();
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        lo = 0;
        hi = win - 1;
      end else begin
        len = $urandom_range(1, (win < 16) ? win : 16);
        lo = $urandom_range(0, win - len);
        hi = lo + len - 1;
      end
      cover_range(lo, hi);
      m = min_left(lo, hi);
      r = $urandom_range(0, 9);
      if (r == 0) amt = '0;
      else if (r == 1) amt = m;
      else amt = $urandom_range(0, m >> $urandom_range(0, 16));
      queue_booking(amt, lo, hi);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || in_ch.valid || reply_q.size() != 0);
    // a trailing load may still be in flight
    repeat (16) @(posedge clk);
  endtask

  task automatic write_slots(input int unsigned v);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= irs_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    slots_cfg = irs_pkg::CFG_W'(v);
    settings_cnt++;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (cur_has_reply) reply_q.push_back(cur_reply);
        else loads_done++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() != 0 && idle_odds != 0 &&
                     $urandom_range(0, idle_odds) == 0) begin
          in_gap = $urandom_range(0, 17);
          in_ch.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          staged = request_q.pop_front();
          in_ch.data <= staged.item;
          in_ch.valid <= 1'b1;
          cur_has_reply = staged.has_reply;
          cur_reply = staged.reply;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction status=%0d booking=%0d",
                                    out_ch.data.status, out_ch.data.booking_number));
        end else begin
          exp_reply = reply_q[0];
          void'(reply_q.pop_front());
          if (out_ch.data.status !== exp_reply.status)
            report_mismatch($sformatf("booking %0d: status %0d, expected %0d",
                                      exp_reply.booking_number, out_ch.data.status,
                                      exp_reply.status));
          if (out_ch.data.booking_number !== exp_reply.booking_number)
            report_mismatch($sformatf("booking_number %0d, expected %0d",
                                      out_ch.data.booking_number,
                                      exp_reply.booking_number));
          if (out_ch.data.first_refused !== exp_reply.first_refused)
            report_mismatch($sformatf("booking %0d: first_refused %0d, expected %0d",
                                      exp_reply.booking_number, out_ch.data.first_refused,
                                      exp_reply.first_refused));
          status_seen[exp_reply.status]++;
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds + 2) == 0) begin
        out_stall = $urandom_range(0, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned s, lo, hi;
    logic [irs_pkg::VAL_W-1:0] m;
    slots_cfg = irs_pkg::SLOTS_RESET;
    idle_odds = 4;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and corner cases at the reset setting
    queue_load(0, '1);
    queue_load(SLOTS - 1, '0);
    queue_load(1, 32'd100);
    queue_load(2, 32'd100);
    queue_load(10'h2AA, 32'hAAAA_AAAA);
    queue_load(10'h155, 32'h5555_5555);
    queue_booking('1, 0, 0);                   // full-width amount, exact fit
    queue_booking('0, SLOTS - 1, SLOTS - 1);   // zero amount on empty slot
    queue_booking(32'd100, 1, 2);              // exact fit over two slots
    queue_booking(32'd5, 2, 1);                // reversed range
    queue_booking('0, 0, 0);
    queue_load(0, '1);
    queue_booking(32'h5555_5555, 10'h2AA, 10'h2AA);
    queue_booking(32'h5555_5555, 10'h155, 10'h155);
    queue_booking(32'd1, 0, 0);
    write_slots(1);
    queue_booking('0, 0, 0);
    queue_booking(32'd1, 0, 1);                // past the slots in use
    queue_booking(32'd1, SLOTS - 1, SLOTS - 1);
    write_slots(0);
    queue_booking('0, 0, 0);                   // nothing in use
    write_slots(2047);
    queue_booking('0, SLOTS - 1, SLOTS - 1);   // saturates to the whole table
    queue_booking(32'd1, 0, 0);

    // random phases over several settings
    write_slots(SLOTS);
    idle_odds = 5;
    repeat (45) queue_random_step();
    wait_drained();                            // sender holds until all replies are in
    idle_odds = 0;
    repeat (30) queue_random_step();
    idle_odds = 2;
    repeat (30) queue_random_step();
    write_slots($urandom_range(2, SLOTS - 1));
    idle_odds = 6;
    repeat (45) queue_random_step();
    write_slots(1);
    repeat (15) queue_random_step();
    write_slots(2);
    repeat (15) queue_random_step();
    write_slots(2047);
    idle_odds = 3;
    repeat (30) queue_random_step();

    // last part: one refusal, then everything is ignored; no idling
    wait_drained();
    idle_odds = 0;
    s = $urandom_range(0, SLOTS - 1);
    lo = (s > 3) ? s - 3 : 0;
    hi = (s + 3 < SLOTS) ? s + 3 : SLOTS - 1;
    queue_load(s, $urandom_range(0, 1000));
    cover_range(lo, hi);
    m = min_left(lo, hi);
    queue_booking(m + 1, lo, hi);
    queue_load(s, '1);
    queue_booking('0, s, s);
    queue_booking(32'd1, 5, 4);
    repeat (20) queue_random_step();

    wait_drained();
    repeat (600) @(posedge clk);
    if (reply_q.size() != 0)
      report_mismatch($sformatf("%0d replies never arrived", reply_q.size()));
    $display("covered %0d loads and %0d bookings over %0d slots_in_use settings",
             loads_done, status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
             settings_cnt);
    $display("replies: %0d admitted, %0d refused, %0d bad range, %0d ignored",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("timeout: %0d requests pending, %0d replies outstanding",
             request_q.size(), reply_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/irs_pkg.sv
rtl/core/irs_chan_if.sv
rtl/core/irs_ram.sv
rtl/core/irs_cell.sv
rtl/core/interval_reservation_admission.sv
sim/interval_reservation_admission_tb.sv
